### rtl/core/hpc_pkg.sv
// ----------------------------------------------------------------------------
// hpc_pkg: shared types and constants of the heater PI controller
// Register indexes, field widths, reset values and the configuration record.
// ----------------------------------------------------------------------------
package hpc_pkg;

  localparam int unsigned TargetW = 15;
  localparam int unsigned GainW   = 16;
  localparam int unsigned IntegW  = 24;
  localparam int unsigned BandW   = 14;
  localparam int unsigned SampleW = 16;
  localparam int unsigned ErrW    = 17;
  localparam int unsigned DutyW   = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 24;

  localparam logic [CfgIdxW-1:0] REG_TARGET = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KP     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KI     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_UPPER  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LOWER  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BAND   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_ENABLE = 3'd6;

  localparam logic [DutyW-1:0] DUTY_MAX = 7'd100;

  localparam logic [TargetW-1:0]       TARGET_RST = 15'd2500;
  localparam logic [GainW-1:0]         KP_RST     = 16'd320;
  localparam logic [GainW-1:0]         KI_RST     = 16'd82;
  localparam logic signed [IntegW-1:0] UPPER_RST  = 24'sd6553600;
  localparam logic signed [IntegW-1:0] LOWER_RST  = 24'sd0;
  localparam logic [BandW-1:0]         BAND_RST   = 14'd250;

  typedef struct packed {
    logic [TargetW-1:0]       target_centideg;
    logic [GainW-1:0]         kp_gain;
    logic [GainW-1:0]         ki_gain;
    logic signed [IntegW-1:0] integ_upper;
    logic signed [IntegW-1:0] integ_lower;
    logic [BandW-1:0]         windup_band;
    logic                     loop_enable;
  } hpc_cfg_t;

endpackage

### rtl/core/hpc_datapath.sv
// ----------------------------------------------------------------------------
// hpc_datapath: control law for one temperature sample
// Error, gated and clamped integrator update, P plus I sum and duty saturation.
// ----------------------------------------------------------------------------
module hpc_datapath (
  input  hpc_pkg::hpc_cfg_t                    cfg,
  input  logic signed [hpc_pkg::SampleW-1:0]   sample,
  input  logic signed [hpc_pkg::IntegW-1:0]    integ,
  output logic signed [hpc_pkg::IntegW-1:0]    integ_next,
  output logic [hpc_pkg::DutyW-1:0]            duty,
  output logic signed [hpc_pkg::ErrW-1:0]      err
);

  logic [hpc_pkg::ErrW-1:0] mag;
  logic                     in_band;
  logic signed [33:0]       ki_prod;
  logic signed [33:0]       kp_prod;
  logic signed [34:0]       acc;
  logic signed [hpc_pkg::IntegW-1:0] clamped;
  logic signed [41:0]       sum;
  logic [25:0]              whole;

  always_comb begin
    err = $signed({2'b00, cfg.target_centideg}) - $signed({sample[15], sample});
    mag = err[16] ? 17'(-err) : 17'(err);
    in_band = mag < {3'b000, cfg.windup_band};

    ki_prod = $signed({1'b0, cfg.ki_gain}) * err;
    kp_prod = $signed({1'b0, cfg.kp_gain}) * err;

    acc = 35'(integ) + (in_band ? 35'(ki_prod) : 35'sd0);

    // Upper limit wins when the limits cross.
    if (acc > 35'(cfg.integ_upper)) begin
      clamped = cfg.integ_upper;
    end else if (acc < 35'(cfg.integ_lower)) begin
      clamped = cfg.integ_lower;
    end else begin
      clamped = acc[23:0];
    end

    // The P product is Q8; move it to Q16 before adding the integrator.
    sum = (42'(kp_prod) <<< 8) + 42'(clamped);
    whole = sum[41:16];

    if (!cfg.loop_enable) begin
      integ_next = integ;
      duty = '0;
    end else begin
      integ_next = clamped;
      if (sum <= 42'sd0) begin
        duty = '0;
      end else if (whole > 26'(hpc_pkg::DUTY_MAX)) begin
        duty = hpc_pkg::DUTY_MAX;
      end else begin
        duty = whole[6:0];
      end
    end
  end

endmodule

### rtl/core/heater_pi_controller.sv
// ----------------------------------------------------------------------------
// heater_pi_controller: PI heater controller with integrator clamp
// Turns temperature samples into heater duty with a windup band and limits.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  sample  | in        | sample_valid, sample_stall | sample_centideg
//  duty    | out       | duty_valid, duty_stall     | heater_duty, error_centideg
//  cfg     | in        | cfg_we                     | cfg_index, cfg_data
//
//  One item per cycle sustained while duty_stall is low; an accepted item goes
//  through the input register, then the result register, to the outputs.
//  The integrator is updated as an item moves into the result register, so
//  the next item in the input register already sees the updated value.
//  Reset restores all register defaults and clears the integrator.
//  A stalled result holds both registers; sample_stall rises only when both
//  stages are full.
// ----------------------------------------------------------------------------
module heater_pi_controller (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [hpc_pkg::SampleW-1:0]   sample_centideg,
  output logic                                 duty_valid,
  input  logic                                 duty_stall,
  output logic [hpc_pkg::DutyW-1:0]            heater_duty,
  output logic signed [hpc_pkg::ErrW-1:0]      error_centideg,
  input  logic                                 cfg_we,
  input  logic [hpc_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [hpc_pkg::CfgW-1:0]             cfg_data
);

  hpc_pkg::hpc_cfg_t                 cfg;
  logic signed [hpc_pkg::IntegW-1:0] integ;
  logic signed [hpc_pkg::IntegW-1:0] integ_next;
  logic                              s1_valid;
  logic signed [hpc_pkg::SampleW-1:0] s1_sample;
  logic                              advance;
  logic                              take;
  logic [hpc_pkg::DutyW-1:0]         duty_next;
  logic signed [hpc_pkg::ErrW-1:0]   err_next;
  logic                              clear_integ;

  assign advance      = !duty_valid || !duty_stall;
  assign sample_stall = s1_valid && !advance;
  assign take         = sample_valid && !sample_stall;
  assign clear_integ  = cfg_we && (cfg_index == hpc_pkg::REG_TARGET ||
                                   cfg_index == hpc_pkg::REG_ENABLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_centideg <= hpc_pkg::TARGET_RST;
      cfg.kp_gain         <= hpc_pkg::KP_RST;
      cfg.ki_gain         <= hpc_pkg::KI_RST;
      cfg.integ_upper     <= hpc_pkg::UPPER_RST;
      cfg.integ_lower     <= hpc_pkg::LOWER_RST;
      cfg.windup_band     <= hpc_pkg::BAND_RST;
      cfg.loop_enable     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        hpc_pkg::REG_TARGET: cfg.target_centideg <= cfg_data[14:0];
        hpc_pkg::REG_KP:     cfg.kp_gain         <= cfg_data[15:0];
        hpc_pkg::REG_KI:     cfg.ki_gain         <= cfg_data[15:0];
        hpc_pkg::REG_UPPER:  cfg.integ_upper     <= $signed(cfg_data);
        hpc_pkg::REG_LOWER:  cfg.integ_lower     <= $signed(cfg_data);
        hpc_pkg::REG_BAND:   cfg.windup_band     <= cfg_data[13:0];
        hpc_pkg::REG_ENABLE: cfg.loop_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      duty_valid <= 1'b0;
      integ      <= '0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        duty_valid <= s1_valid;
      end
      if (clear_integ) begin
        integ <= '0;
      end else if (advance && s1_valid) begin
        integ <= integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_sample <= sample_centideg;
    end
    if (advance && s1_valid) begin
      heater_duty    <= duty_next;
      error_centideg <= err_next;
    end
  end

  hpc_datapath u_datapath (
    .cfg        (cfg),
    .sample     (s1_sample),
    .integ      (integ),
    .integ_next (integ_next),
    .duty       (duty_next),
    .err        (err_next)
  );

`ifndef ASSERT_OFF
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    duty_valid |-> heater_duty <= hpc_pkg::DUTY_MAX)
    else $error("heater duty above its maximum");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> s1_valid && duty_valid)
    else $error("sample stalled with a free stage");

  a_hold_disabled: assert property (@(posedge clk) disable iff (rst)
    !cfg.loop_enable && !cfg_we |=> $stable(integ))
    else $error("integrator moved while the loop is disabled");

  a_integ_clamped: assert property (@(posedge clk) disable iff (rst)
    advance && s1_valid && cfg.loop_enable && !cfg_we |=>
      (integ <= cfg.integ_upper || integ == cfg.integ_lower))
    else $error("integrator outside its limits after an update");
`endif

endmodule

### bench/hpc_duty_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hpc_duty_checker: result checker for the heater PI controller
// Mirrors the register writes, predicts duty and error for every accepted
// sample item and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module hpc_duty_checker
  import hpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  input  logic                      sample_stall,
  input  logic signed [SampleW-1:0] sample_centideg,
  input  logic                      duty_valid,
  input  logic                      duty_stall,
  input  logic [DutyW-1:0]          heater_duty,
  input  logic signed [ErrW-1:0]    error_centideg,
  input  logic                      cfg_we,
  input  logic [CfgIdxW-1:0]        cfg_index,
  input  logic [CfgW-1:0]           cfg_data,
  output int                        mismatch_count,
  output int                        results_owed
);

  typedef struct {
    logic [DutyW-1:0]       duty;
    logic signed [ErrW-1:0] err;
  } duty_result_t;

  duty_result_t duty_expected_q[$];
  duty_result_t oldest;

  logic [TargetW-1:0]       set_target;
  logic [GainW-1:0]         gain_p;
  logic [GainW-1:0]         gain_i;
  logic signed [IntegW-1:0] integ_hi;
  logic signed [IntegW-1:0] integ_lo;
  logic [BandW-1:0]         band_width;
  logic                     loop_on;
  logic signed [31:0]       integ_q16;

  // Advances the integrator while the loop is on and returns the duty and error for one sample.
  function automatic duty_result_t predict_duty(input logic signed [SampleW-1:0] s);
    longint       err;
    longint       mag;
    longint       acc;
    longint       sum;
    duty_result_t r;
    err = longint'(set_target) - longint'(s);
    r.err = err[ErrW-1:0];
    r.duty = '0;
    if (loop_on) begin
      acc = longint'(integ_q16);
      mag = (err < 0) ? -err : err;
      if (mag < longint'(band_width)) begin
        acc = acc + longint'(gain_i) * err;
      end
      // Upper limit wins when the limits are crossed.
      if (acc > longint'(integ_hi)) begin
        acc = longint'(integ_hi);
      end else if (acc < longint'(integ_lo)) begin
        acc = longint'(integ_lo);
      end
      integ_q16 = acc[31:0];
      sum = longint'(gain_p) * err * 256 + acc;
      if (sum > 0) begin
        sum = sum >>> 16;
        r.duty = (sum > 100) ? DUTY_MAX : sum[DutyW-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      set_target = TARGET_RST;
      gain_p = KP_RST;
      gain_i = KI_RST;
      integ_hi = UPPER_RST;
      integ_lo = LOWER_RST;
      band_width = BAND_RST;
      loop_on = 1'b0;
      integ_q16 = '0;
      duty_expected_q.delete();
      mismatch_count = 0;
    end else begin
      if (duty_valid && !duty_stall) begin
        if (duty_expected_q.size() == 0) begin
          $display("%0t: result item with nothing expected: heater_duty %0d error_centideg %0d",
                   $time, heater_duty, error_centideg);
          mismatch_count++;
        end else begin
          oldest = duty_expected_q.pop_front();
          if (heater_duty !== oldest.duty) begin
            $display("%0t: heater_duty expected %0d, actual %0d",
                     $time, oldest.duty, heater_duty);
            mismatch_count++;
          end
          if (error_centideg !== oldest.err) begin
            $display("%0t: error_centideg expected %0d, actual %0d",
                     $time, oldest.err, error_centideg);
            mismatch_count++;
          end
        end
      end
      if (sample_valid && !sample_stall) begin
        duty_expected_q.push_back(predict_duty(sample_centideg));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET: begin
            set_target = cfg_data[TargetW-1:0];
            integ_q16 = '0;
          end
          REG_KP:     gain_p = cfg_data[GainW-1:0];
          REG_KI:     gain_i = cfg_data[GainW-1:0];
          REG_UPPER:  integ_hi = cfg_data[IntegW-1:0];
          REG_LOWER:  integ_lo = cfg_data[IntegW-1:0];
          REG_BAND:   band_width = cfg_data[BandW-1:0];
          REG_ENABLE: begin
            loop_on = cfg_data[0];
            integ_q16 = '0;
          end
          default: ;
        endcase
      end
    end
    results_owed = duty_expected_q.size();
  end

endmodule

### bench/heater_pi_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heater_pi_controller_tb: testbench of the heater PI controller
// Drives directed and random sample items under several register settings
// and flow-control patterns; a checker beside the block judges every result.
// ----------------------------------------------------------------------------
module heater_pi_controller_tb;
  import hpc_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      sample_valid = 1'b0;
  logic                      sample_stall;
  logic signed [SampleW-1:0] sample_centideg = '0;
  logic                      duty_valid;
  logic                      duty_stall = 1'b0;
  logic [DutyW-1:0]          heater_duty;
  logic signed [ErrW-1:0]    error_centideg;
  logic                      cfg_we = 1'b0;
  logic [CfgIdxW-1:0]        cfg_index = '0;
  logic [CfgW-1:0]           cfg_data = '0;

  int mismatch_count;
  int results_owed;
  int src_idle_pct = 23;
  int sink_stall_pct = 64;
  int tgt_shadow = 2500;
  int band_shadow = 250;

  heater_pi_controller dut (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .sample_centideg (sample_centideg),
    .duty_valid      (duty_valid),
    .duty_stall      (duty_stall),
    .heater_duty     (heater_duty),
    .error_centideg  (error_centideg),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  hpc_duty_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .sample_centideg (sample_centideg),
    .duty_valid      (duty_valid),
    .duty_stall      (duty_stall),
    .heater_duty     (heater_duty),
    .error_centideg  (error_centideg),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_owed    (results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    duty_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Leaves valid high after acceptance so that the next item can follow at once.
  task automatic send_sample(input logic signed [SampleW-1:0] v);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_centideg <= v;
    do @(posedge clk); while (sample_stall);
  endtask

  // Holds off the sender until every outstanding result has come back.
  task automatic settle();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == REG_TARGET) tgt_shadow = int'(data[TargetW-1:0]);
    if (idx == REG_BAND) band_shadow = int'(data[BandW-1:0]);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Most samples sit close to the target so that the integrator stays busy.
  function automatic logic signed [SampleW-1:0] pick_sample();
    int r;
    int span;
    int v;
    r = $urandom_range(99);
    span = band_shadow + 50;
    if (r < 60) begin
      v = tgt_shadow + int'($urandom_range(2 * span)) - span;
    end else if (r < 85) begin
      v = tgt_shadow + int'($urandom_range(6000)) - 3000;
    end else begin
      v = int'($urandom_range(65535)) - 32768;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SampleW-1:0];
  endfunction

  function automatic logic [CfgW-1:0] pick_limit();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 24'sd6553600;
    if (r == 1) return -24'sd6553600;
    return CfgW'(int'($urandom_range(13107200)) - 6553600);
  endfunction

  task automatic shuffle_settings();
    int r;
    int lo;
    int hi;
    logic [CfgW-1:0] data;
    if ($urandom_range(1)) begin
      r = $urandom_range(9);
      write_reg(REG_TARGET, (r == 0) ? CfgW'($urandom) : CfgW'($urandom_range(30000)));
    end
    if ($urandom_range(2) != 0) begin
      r = $urandom_range(19);
      if (r == 0) write_reg(REG_KP, 24'd0);
      else if (r == 1) write_reg(REG_KP, 24'd65535);
      else if (r < 5) write_reg(REG_KP, CfgW'($urandom));
      else write_reg(REG_KP, CfgW'($urandom_range(1023)));
    end
    if ($urandom_range(2) != 0) begin
      r = $urandom_range(19);
      if (r == 0) write_reg(REG_KI, 24'd0);
      else if (r == 1) write_reg(REG_KI, 24'd65535);
      else write_reg(REG_KI, CfgW'($urandom_range(8191)));
    end
    if ($urandom_range(2) != 0) begin
      r = $urandom_range(9);
      if (r < 2) begin
        // Limits in any order, crossed ones included.
        write_reg(REG_UPPER, pick_limit());
        write_reg(REG_LOWER, pick_limit());
      end else begin
        lo = int'($urandom_range(6553600)) - 6553600;
        hi = int'($urandom_range(6553600));
        write_reg(REG_UPPER, CfgW'(hi));
        write_reg(REG_LOWER, CfgW'(lo));
      end
    end
    if ($urandom_range(2) != 0) begin
      r = $urandom_range(19);
      if (r == 0) write_reg(REG_BAND, 24'd0);
      else if (r == 1) write_reg(REG_BAND, 24'd10000);
      else write_reg(REG_BAND, CfgW'($urandom_range(1000)));
    end
    if ($urandom_range(9) < 7) begin
      data = CfgW'($urandom);
      data[0] = ($urandom_range(7) != 0);
      write_reg(REG_ENABLE, data);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Loop disabled after reset: the duty stays at zero.
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    send_sample(16'sd0);
    settle();

    // Default gains: band edges, saturation, negative sum, the smallest duty.
    write_reg(REG_ENABLE, 24'd1);
    send_sample(16'sd2500);
    send_sample(16'sd2250);
    send_sample(16'sd2251);
    send_sample(16'sd2749);
    send_sample(16'sd0);
    send_sample(16'sd2600);
    send_sample(16'sd2499);
    send_sample(16'sd2450);
    settle();

    // Integrator clamped at both limits, then with the limits crossed.
    write_reg(REG_KI, 24'd65535);
    write_reg(REG_BAND, 24'hFFFFFF);
    write_reg(REG_UPPER, 24'sd200000);
    write_reg(REG_LOWER, -24'sd200000);
    write_reg(REG_KP, 24'd0);
    send_sample(16'sd2400);
    send_sample(16'sd2600);
    settle();
    write_reg(REG_UPPER, -24'sd100000);
    write_reg(REG_LOWER, 24'sd100000);
    send_sample(16'sd2500);
    send_sample(16'sd2499);
    settle();

    // Largest gain, target beyond its range, error extremes, unused index.
    write_reg(REG_KP, 24'd65535);
    write_reg(REG_UPPER, 24'sd6553600);
    write_reg(REG_LOWER, -24'sd6553600);
    write_reg(REG_TARGET, 24'hFFFFFF);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
    settle();
    write_reg(REG_TARGET, 24'd0);
    write_reg(REG_UNUSED, 24'h5A5A5A);
    send_sample(16'sd32767);
    send_sample(16'sd1);
    settle();

    for (int phase = 0; phase < 12; phase++) begin
      if (phase < 4) begin
        src_idle_pct = 23;
        sink_stall_pct = 64;
      end else if (phase < 8) begin
        src_idle_pct = 64;
        sink_stall_pct = 23;
      end else begin
        src_idle_pct = 0;
        sink_stall_pct = 0;
      end
      shuffle_settings();
      for (int n = 0; n < 100; n++) begin
        send_sample(pick_sample());
      end
      settle();
    end

    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
rtl/core/hpc_pkg.sv
rtl/core/hpc_datapath.sv
rtl/core/heater_pi_controller.sv
bench/hpc_duty_checker.sv
bench/heater_pi_controller_tb.sv
